// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the next rising edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/owsc_pkg.sv -----
// ----------------------------------------------------------------------------
// owsc_pkg
// Types, constants and the CRC-8 step shared by the scratchpad checker.
// ----------------------------------------------------------------------------
package owsc_pkg;

  localparam int IDX_W = 4;

  // Bytes in one scratchpad frame
  localparam logic [IDX_W-1:0] FRAME_BYTES = 4'd9;

  // Reflected CRC-8 polynomial, LSB first
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic STATUS_GOOD  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
  } owsc_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               status;
  } owsc_result_t;

  // One byte through the CRC, bit 0 first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

// ----- hdl/owsc_in_reg.sv -----
// ----------------------------------------------------------------------------
// owsc_in_reg
// Input register: captures one item and holds it until the frame logic
// takes it.
// ----------------------------------------------------------------------------
module owsc_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 first_of_frame,
  input  logic                 valid,
  output logic                 stall,
  input  logic                 take,
  output logic                 item_valid,
  output owsc_pkg::owsc_item_t item
);

  // Hold while the stored item cannot move on
  assign stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!stall) begin
      item_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && !stall) begin
      item.data_byte      <= data_byte;
      item.first_of_frame <= first_of_frame;
    end
  end

endmodule

// ----- hdl/owsc_frame.sv -----
// ----------------------------------------------------------------------------
// owsc_frame
// Frame tracker: running CRC, byte count and temperature bytes; builds the
// result when the last byte of a frame is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owsc_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  owsc_pkg::owsc_item_t   item,
  input  logic                   out_busy,
  output logic                   take,
  output logic                   res_valid,
  output owsc_pkg::owsc_result_t res
);

  logic [7:0]                   running_crc;
  logic [owsc_pkg::IDX_W-1:0]   byte_index;
  logic [7:0]                   temp_low_byte;
  logic [7:0]                   temp_high_byte;

  logic [7:0]                   base_crc;
  logic [owsc_pkg::IDX_W-1:0]   base_index;
  logic [7:0]                   crc_next;
  logic [owsc_pkg::IDX_W-1:0]   index_next;
  logic [7:0]                   low_next;
  logic [7:0]                   high_next;
  logic                         done;

  always_comb begin
    // A marked byte restarts the frame
    base_crc   = item.first_of_frame ? 8'h00 : running_crc;
    base_index = item.first_of_frame ? '0 : byte_index;
    crc_next   = owsc_pkg::crc8_update(base_crc, item.data_byte);
    index_next = base_index + 1'b1;
    low_next   = (base_index == 4'd0) ? item.data_byte : temp_low_byte;
    high_next  = (base_index == 4'd1) ? item.data_byte : temp_high_byte;
    done       = (index_next == owsc_pkg::FRAME_BYTES);
  end

  // A frame-ending item waits while the result register is full and stalled
  assign take      = item_valid && (!done || !out_busy);
  assign res_valid = take && done;

  always_comb begin
    res.temperature = {high_next, low_next};
    res.status      = (crc_next != 8'h00) ? owsc_pkg::STATUS_ERROR
                                          : owsc_pkg::STATUS_GOOD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= 8'h00;
      byte_index     <= '0;
      temp_low_byte  <= 8'h00;
      temp_high_byte <= 8'h00;
    end else if (take) begin
      temp_low_byte  <= low_next;
      temp_high_byte <= high_next;
      if (done) begin
        running_crc <= 8'h00;
        byte_index  <= '0;
      end else begin
        running_crc <= crc_next;
        byte_index  <= index_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_index_in_frame, byte_index < owsc_pkg::FRAME_BYTES, "byte count left frame range")
  `ASSERT_ALWAYS(a_no_overwrite, !(res_valid && out_busy), "result issued into a full register")
  `ASSERT_NEXT(a_clear_on_done, res_valid, (byte_index == '0) && (running_crc == 8'h00), "frame not cleared after result")

endmodule

// ----- hdl/owsc_out_reg.sv -----
// ----------------------------------------------------------------------------
// owsc_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module owsc_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  owsc_pkg::owsc_result_t res,
  input  logic                   stall,
  output logic                   valid,
  output logic signed [15:0]     temperature,
  output logic                   status,
  output logic                   busy
);

  assign busy = valid && stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_valid) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      temperature <= res.temperature;
      status      <= res.status;
    end
  end

endmodule

// ----- hdl/onewire_scratchpad_checker_top.sv -----
// ----------------------------------------------------------------------------
// onewire_scratchpad_checker_top
// Checks 1-Wire scratchpad frames byte by byte and reports temperature and
// CRC status once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one scratchpad byte per item, with
//   first_of_frame set on the first byte of a frame to restart CRC and count.
//   Output channel (out_valid / out_stall): one item per completed frame of
//   FRAME_BYTES bytes, temperature as signed Q12.4 from bytes 1:0 and status
//   0 for a good CRC, 1 for a mismatch.
//   Throughput: one byte per cycle while no frame-ending byte is held back.
//   The CRC pass over a byte is combinational logic that feeds the result
//   register. Path: an accepted byte waits in the input register, and the
//   result of a frame-ending byte is loaded into the result register.
//   Reset: clears both valid flags, the running CRC and the byte count.
//   Receiver stall: the result holds; bytes that do not end a frame still
//   flow, and a frame-ending byte waits in the input register, which then
//   stalls the sender.
// ----------------------------------------------------------------------------
module onewire_scratchpad_checker_top (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               first_of_frame,
  input  logic               in_valid,
  output logic               in_stall,
  output logic signed [15:0] temperature,
  output logic               status,
  output logic               out_valid,
  input  logic               out_stall
);

  logic                   item_valid;
  owsc_pkg::owsc_item_t   item;
  logic                   take;
  logic                   res_valid;
  owsc_pkg::owsc_result_t res;
  logic                   out_busy;

  owsc_in_reg u_in_reg (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .valid          (in_valid),
    .stall          (in_stall),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item)
  );

  owsc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_busy   (out_busy),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  owsc_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .stall       (out_stall),
    .valid       (out_valid),
    .temperature (temperature),
    .status      (status),
    .busy        (out_busy)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Scratchpad checker testbench
// Sends 1-Wire scratchpad bytes into onewire_scratchpad_checker_top and
// predicts each frame's temperature and CRC status in a local scoreboard.
// It covers directed frames for the edge cases, random well-formed frames
// mixed with partial and noisy byte runs, a long receiver hold-off, and
// random idle gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic [7:0]         data_byte      = 8'h00;
  logic               first_of_frame = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic signed [15:0] temperature;
  logic               status;
  logic               out_valid;
  logic               out_stall      = 1'b0;

  onewire_scratchpad_checker_top dut (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .temperature    (temperature),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  // Scoreboard copy of the frame state
  logic [7:0]                 pad_crc   = 8'h00;
  logic [owsc_pkg::IDX_W-1:0] pad_count = '0;
  logic [7:0]                 pad_lo    = 8'h00;
  logic [7:0]                 pad_hi    = 8'h00;
  owsc_pkg::owsc_result_t     expected_readings[$];

  int unsigned send_gap_pct  = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_left    = 0;
  int unsigned hold_off_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_started = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned readings_seen = 0;
  int unsigned bad_frames    = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
               expected_readings.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Reflected CRC-8, one byte, bit 0 first
  function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc,
                                                input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[7:1]} ^ (fb ? owsc_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_temperature();
    int t;
    if ($urandom_range(0, 1) != 0) begin
      // -55 to +125 degrees
      t = int'($urandom_range(0, 2880)) - 880;
      return t[15:0];
    end
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic mark);
    owsc_pkg::owsc_result_t reading;
    if (mark) begin
      pad_crc   = 8'h00;
      pad_count = '0;
    end
    pad_crc = crc_shift_byte(pad_crc, b);
    if (pad_count == 0) begin
      pad_lo = b;
    end else if (pad_count == 1) begin
      pad_hi = b;
    end
    pad_count = pad_count + 1'b1;
    if (pad_count == owsc_pkg::FRAME_BYTES) begin
      reading.temperature = {pad_hi, pad_lo};
      reading.status      = (pad_crc != 8'h00) ? owsc_pkg::STATUS_ERROR
                                               : owsc_pkg::STATUS_GOOD;
      if (reading.status == owsc_pkg::STATUS_ERROR) bad_frames++;
      expected_readings.push_back(reading);
      pad_crc   = 8'h00;
      pad_count = '0;
    end
  endtask

  // Offer one item, hold it until taken, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    in_valid       <= 1'b1;
    data_byte      <= b;
    first_of_frame <= mark;
    do @(posedge clk); while (in_stall);
    track_byte(b, mark);
    bytes_sent++;
    gap = idle_len(send_gap_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Temperature bytes, random filler, then the check byte (corrupted if bad)
  task automatic send_frame(input logic [15:0] temp, input bit good, input logic mark);
    logic [7:0] b;
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < owsc_pkg::FRAME_BYTES - 1; i++) begin
      if (i == 0) b = temp[7:0];
      else if (i == 1) b = temp[15:8];
      else b = 8'($urandom_range(0, 255));
      crc = crc_shift_byte(crc, b);
      send_byte(b, mark && (i == 0));
    end
    if (!good) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    send_byte(crc, 1'b0);
  endtask

  task automatic set_pacing(input int unsigned send_pct, input int unsigned out_pct);
    send_gap_pct = send_pct;
    stall_pct   <= out_pct;
  endtask

  task automatic wait_for_readings();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    int unsigned len;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_requests != holds_started) begin
      // start a long hold-off
      out_stall     <= 1'b1;
      holds_started <= hold_requests;
      hold_off_left <= HOLD_CYCLES - 1;
    end else if (hold_off_left != 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      len = idle_len(stall_pct);
      out_stall  <= (len != 0);
      stall_left <= (len != 0) ? len - 1 : 0;
    end
  end

  always @(posedge clk) begin
    owsc_pkg::owsc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: temperature %0d status %0b", temperature, status);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        readings_seen++;
        if (temperature !== want.temperature) begin
          $error("temperature: expected %0d, got %0d", $signed(want.temperature),
                 temperature);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, status);
          fail_count++;
        end
      end
    end
  end

  // Marked good frame at the top of the range; bytes 1..8 arrive unmarked
  task automatic test_good_frame();
    set_pacing(0, 0);
    send_frame(16'h7FFF, 1'b1, 1'b1);
  endtask

  // Unmarked bytes after a finished frame start a new one, then a mark drops
  // them; the restarted frame carries the most negative value and a bad CRC
  task automatic test_early_mark();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_frame(16'h8000, 1'b0, 1'b1);
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned run;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      // change pacing now and then, sometimes to no idling at all
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: set_pacing(0, 0);
          1: set_pacing(30, 30);
          2: set_pacing(10, 50);
          default: set_pacing(50, 10);
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_frame(pick_temperature(), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 9) != 0);
      end else if (pick < 90) begin
        // partial frame: a marked run shorter than a frame
        run = $urandom_range(1, owsc_pkg::FRAME_BYTES - 1);
        for (int i = 0; i < run; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
      end else begin
        run = $urandom_range(1, 20);
        for (int i = 0; i < run; i++) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
      end
    end
  endtask

  task automatic test_steady_stream(input int unsigned n_frames);
    set_pacing(0, 0);
    repeat (n_frames) send_frame(pick_temperature(), $urandom_range(0, 1) != 0, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering; input must back up
  task automatic test_receiver_hold();
    set_pacing(0, 0);
    hold_requests <= hold_requests + 1;
    repeat (5) send_frame(pick_temperature(), 1'b1, 1'b1);
  endtask

  task automatic test_output_stalls();
    set_pacing(0, 70);
    repeat (16) send_frame(pick_temperature(), $urandom_range(0, 3) != 0, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_frame();
    test_early_mark();
    wait_for_readings();
    test_random_frames(850);
    wait_for_readings();
    test_steady_stream(13);
    wait_for_readings();
    test_receiver_hold();
    wait_for_readings();
    test_output_stalls();
    wait_for_readings();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes, checked %0d readings (%0d with CRC errors)", bytes_sent,
             readings_seen, bad_frames);
    $display("covered partial and unmarked frames, a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/owsc_pkg.sv
hdl/owsc_in_reg.sv
hdl/owsc_frame.sv
hdl/owsc_out_reg.sv
hdl/onewire_scratchpad_checker_top.sv
tb/sv/testbench.sv
